>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by quaternion_orientation_unit_core; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define QOU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define QOU_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QOU_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define QOU_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/qou_pkg.sv
// ----------------------------------------------------------------------------
// qou_pkg
// Types, constants and the product-term table of the orientation unit.
// ----------------------------------------------------------------------------
package qou_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DW        = 16;
    localparam int ACC_W     = 36;
    localparam int RAD_W     = 33;
    localparam int ROOT_W    = 17;
    localparam int NUM_W     = DW + FRAC_BITS;
    localparam int RD_W      = 35;
    localparam int ROM_AW    = 6;
    localparam int TOL_W     = 15;

    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = 36'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -36'sd32768;
    localparam logic [ROOT_W-1:0]       MAG_ONE  = ROOT_W'(1) << FRAC_BITS;
    localparam logic [TOL_W-1:0]        TOL_RESET = 15'd1638;

    // operand selects: stored quaternion, then input quaternion
    localparam logic [2:0] SEL_QW = 3'd0;
    localparam logic [2:0] SEL_QX = 3'd1;
    localparam logic [2:0] SEL_QY = 3'd2;
    localparam logic [2:0] SEL_QZ = 3'd3;
    localparam logic [2:0] SEL_IW = 3'd4;
    localparam logic [2:0] SEL_IX = 3'd5;
    localparam logic [2:0] SEL_IY = 3'd6;
    localparam logic [2:0] SEL_IZ = 3'd7;

    // term table bursts
    localparam logic [ROM_AW-1:0] HAM_BASE = 6'd0;
    localparam logic [ROM_AW-1:0] HAM_LAST = 6'd15;
    localparam logic [ROM_AW-1:0] MAT_BASE = 6'd16;
    localparam logic [ROM_AW-1:0] MAT_LAST = 6'd33;
    localparam logic [ROM_AW-1:0] MAG_BASE = 6'd34;
    localparam logic [ROM_AW-1:0] MAG_LAST = 6'd37;

    localparam logic RD_SQRT = 1'b0;
    localparam logic RD_DIV  = 1'b1;

    typedef struct packed {
        logic [1:0]           mode;
        logic signed [DW-1:0] in_w;
        logic signed [DW-1:0] in_x;
        logic signed [DW-1:0] in_y;
        logic signed [DW-1:0] in_z;
    } qou_in_t;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [DW-1:0] elem_a;
        logic signed [DW-1:0] elem_b;
        logic signed [DW-1:0] elem_c;
        logic signed [DW-1:0] quat_w;
        logic signed [DW-1:0] quat_x;
        logic signed [DW-1:0] quat_y;
        logic signed [DW-1:0] quat_z;
        logic                 is_unit;
        logic                 last_row;
    } qou_out_t;

    typedef struct packed {
        logic first;
        logic init_one;
        logic neg;
        logic dbl;
        logic last;
    } qou_mac_ctl_t;

    typedef struct packed {
        logic [2:0]   sel_a;
        logic [2:0]   sel_b;
        qou_mac_ctl_t ctl;
    } qou_term_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] value;
    } qou_rd_res_t;

    function automatic qou_term_t mk_term(input logic [2:0] a, input logic [2:0] b,
                                          input logic neg, input logic dbl,
                                          input logic first, input logic one,
                                          input logic last);
        qou_term_t t;
        t.sel_a        = a;
        t.sel_b        = b;
        t.ctl.first    = first;
        t.ctl.init_one = one;
        t.ctl.neg      = neg;
        t.ctl.dbl      = dbl;
        t.ctl.last     = last;
        return t;
    endfunction

    // args: a, b, neg, dbl, first, init_one, last
    function automatic qou_term_t term_rom(input logic [ROM_AW-1:0] addr);
        qou_term_t t;
        case (addr)
            // Hamilton product q * p
            6'd0:  t = mk_term(SEL_QW, SEL_IW, 0, 0, 1, 0, 0);
            6'd1:  t = mk_term(SEL_QX, SEL_IX, 1, 0, 0, 0, 0);
            6'd2:  t = mk_term(SEL_QY, SEL_IY, 1, 0, 0, 0, 0);
            6'd3:  t = mk_term(SEL_QZ, SEL_IZ, 1, 0, 0, 0, 1);
            6'd4:  t = mk_term(SEL_QW, SEL_IX, 0, 0, 1, 0, 0);
            6'd5:  t = mk_term(SEL_QX, SEL_IW, 0, 0, 0, 0, 0);
            6'd6:  t = mk_term(SEL_QY, SEL_IZ, 0, 0, 0, 0, 0);
            6'd7:  t = mk_term(SEL_QZ, SEL_IY, 1, 0, 0, 0, 1);
            6'd8:  t = mk_term(SEL_QW, SEL_IY, 0, 0, 1, 0, 0);
            6'd9:  t = mk_term(SEL_QX, SEL_IZ, 1, 0, 0, 0, 0);
            6'd10: t = mk_term(SEL_QY, SEL_IW, 0, 0, 0, 0, 0);
            6'd11: t = mk_term(SEL_QZ, SEL_IX, 0, 0, 0, 0, 1);
            6'd12: t = mk_term(SEL_QW, SEL_IZ, 0, 0, 1, 0, 0);
            6'd13: t = mk_term(SEL_QX, SEL_IY, 0, 0, 0, 0, 0);
            6'd14: t = mk_term(SEL_QY, SEL_IX, 1, 0, 0, 0, 0);
            6'd15: t = mk_term(SEL_QZ, SEL_IW, 0, 0, 0, 0, 1);
            // rotation matrix, row major
            6'd16: t = mk_term(SEL_QY, SEL_QY, 1, 1, 1, 1, 0);
            6'd17: t = mk_term(SEL_QZ, SEL_QZ, 1, 1, 0, 0, 1);
            6'd18: t = mk_term(SEL_QX, SEL_QY, 0, 1, 1, 0, 0);
            6'd19: t = mk_term(SEL_QZ, SEL_QW, 1, 1, 0, 0, 1);
            6'd20: t = mk_term(SEL_QX, SEL_QZ, 0, 1, 1, 0, 0);
            6'd21: t = mk_term(SEL_QY, SEL_QW, 0, 1, 0, 0, 1);
            6'd22: t = mk_term(SEL_QX, SEL_QY, 0, 1, 1, 0, 0);
            6'd23: t = mk_term(SEL_QZ, SEL_QW, 0, 1, 0, 0, 1);
            6'd24: t = mk_term(SEL_QX, SEL_QX, 1, 1, 1, 1, 0);
            6'd25: t = mk_term(SEL_QZ, SEL_QZ, 1, 1, 0, 0, 1);
            6'd26: t = mk_term(SEL_QY, SEL_QZ, 0, 1, 1, 0, 0);
            6'd27: t = mk_term(SEL_QX, SEL_QW, 1, 1, 0, 0, 1);
            6'd28: t = mk_term(SEL_QX, SEL_QZ, 0, 1, 1, 0, 0);
            6'd29: t = mk_term(SEL_QY, SEL_QW, 1, 1, 0, 0, 1);
            6'd30: t = mk_term(SEL_QY, SEL_QZ, 0, 1, 1, 0, 0);
            6'd31: t = mk_term(SEL_QX, SEL_QW, 0, 1, 0, 0, 1);
            6'd32: t = mk_term(SEL_QX, SEL_QX, 1, 1, 1, 1, 0);
            6'd33: t = mk_term(SEL_QY, SEL_QY, 1, 1, 0, 0, 1);
            // squared magnitude
            6'd34: t = mk_term(SEL_QW, SEL_QW, 0, 0, 1, 0, 0);
            6'd35: t = mk_term(SEL_QX, SEL_QX, 0, 0, 0, 0, 0);
            6'd36: t = mk_term(SEL_QY, SEL_QY, 0, 0, 0, 0, 0);
            6'd37: t = mk_term(SEL_QZ, SEL_QZ, 0, 0, 0, 0, 1);
            default: t = mk_term(SEL_QW, SEL_QW, 0, 0, 1, 0, 1);
        endcase
        return t;
    endfunction

    // round half up at the fraction point, then clamp to 16 bits
    function automatic logic signed [DW-1:0] scale_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] s;
        t = v + ACC_HALF;
        s = t >>> FRAC_BITS;
        if (s > SAT_MAX) begin
            s = SAT_MAX;
        end else if (s < SAT_MIN) begin
            s = SAT_MIN;
        end
        return s[DW-1:0];
    endfunction

endpackage

>>> rtl/core/qou_mac.sv
// ----------------------------------------------------------------------------
// qou_mac
// Shared 16x16 multiplier with a registered product and a 36-bit accumulator.
// ----------------------------------------------------------------------------
module qou_mac
    import qou_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    issue,
    input  logic signed [DW-1:0]    op_a,
    input  logic signed [DW-1:0]    op_b,
    input  qou_mac_ctl_t            ctl,
    output logic                    res_valid,
    output logic signed [ACC_W-1:0] res
);

    logic signed [2*DW-1:0]  prod_reg;
    qou_mac_ctl_t            ctl_reg;
    logic                    vld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= issue;
        end
        prod_reg <= op_a * op_b;
        ctl_reg  <= ctl;
        if (vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        term = {{(ACC_W-2*DW){prod_reg[2*DW-1]}}, prod_reg};
        if (ctl_reg.dbl) begin
            term = term <<< 1;
        end
        if (ctl_reg.neg) begin
            term = -term;
        end
        if (ctl_reg.first) begin
            acc_base = ctl_reg.init_one ? ACC_ONE : '0;
        end else begin
            acc_base = acc_reg;
        end
        acc_next = acc_base + term;
    end

    assign res_valid = vld_reg & ctl_reg.last;
    assign res       = acc_next;

endmodule

>>> rtl/core/qou_rootdiv.sv
// ----------------------------------------------------------------------------
// qou_rootdiv
// One-bit-per-cycle square root and divider sharing a single subtractor.
// ----------------------------------------------------------------------------
module qou_rootdiv
    import qou_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 op,
    input  logic [RAD_W-1:0]     rad,
    input  logic signed [DW-1:0] numer,
    input  logic [ROOT_W-1:0]    divisor,
    output qou_rd_res_t          res
);

    localparam logic [4:0] SQRT_STEPS = 5'(ROOT_W - 1);
    localparam logic [4:0] DIV_STEPS  = 5'(NUM_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic              op_reg;
    logic              neg_reg;
    logic [4:0]        cnt_reg;
    logic [RD_W-1:0]   n_reg;
    logic [RD_W-1:0]   r_reg;
    logic [RD_W-1:0]   bit_reg;
    logic [ROOT_W-1:0] dvs_reg;

    logic [RD_W:0]     sub_a;
    logic [RD_W:0]     sub_b;
    logic [RD_W:0]     diff;
    logic              fits;
    logic [DW-1:0]     abs_num;
    logic [NUM_W-1:0]  quot;
    logic [DW-1:0]     qsat;
    logic [ROOT_W-1:0] root_rnd;

    assign abs_num = numer[DW-1] ? DW'(-numer) : DW'(numer);

    // sqrt: n - (r + bit); divide: {rem, next numerator bit} - divisor
    always_comb begin
        if (op_reg == RD_SQRT) begin
            sub_a = {1'b0, n_reg};
            sub_b = {1'b0, r_reg + bit_reg};
        end else begin
            sub_a = (RD_W+1)'({n_reg[ROOT_W-1:0], r_reg[NUM_W-1]});
            sub_b = (RD_W+1)'(dvs_reg);
        end
        diff = sub_a - sub_b;
        fits = ~diff[RD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            op_reg  <= op;
            neg_reg <= numer[DW-1];
            dvs_reg <= divisor;
            if (op == RD_SQRT) begin
                cnt_reg <= SQRT_STEPS;
                n_reg   <= RD_W'(rad);
                r_reg   <= '0;
                bit_reg <= RD_W'(1) << (2 * (ROOT_W - 1));
            end else begin
                cnt_reg <= DIV_STEPS;
                n_reg   <= '0;
                r_reg   <= RD_W'({abs_num, FRAC_BITS'(0)} + NUM_W'(divisor >> 1));
                bit_reg <= '0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (op_reg == RD_SQRT) begin
                if (fits) begin
                    n_reg <= diff[RD_W-1:0];
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end else begin
                n_reg <= fits ? diff[RD_W-1:0] : sub_a[RD_W-1:0];
                r_reg <= {r_reg[RD_W-2:0], fits};
            end
        end
    end

    always_comb begin
        quot     = r_reg[NUM_W-1:0];
        root_rnd = (n_reg > r_reg) ? r_reg[ROOT_W-1:0] + 1'b1 : r_reg[ROOT_W-1:0];
        if (neg_reg) begin
            qsat = (quot > NUM_W'(32768)) ? 16'h8000 : DW'(-quot);
        end else begin
            qsat = (quot > NUM_W'(32767)) ? 16'h7FFF : quot[DW-1:0];
        end
        res.done  = done_reg;
        res.value = (op_reg == RD_SQRT) ? root_rnd : {qsat[DW-1], qsat};
    end

endmodule

>>> rtl/core/quaternion_orientation_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_orientation_unit_core
// Orientation quaternion store with multiply, normalise and matrix readout.
// ----------------------------------------------------------------------------
// One item at a time: s_ready is high only while the core is idle. A load or
// unused-mode item, a multiply and a normalise are each followed by three
// result beats (one per matrix row). The work is done by the single shared
// multiplier, which takes one product term per cycle (16 for the Hamilton
// product, 18 for the matrix, 4 per squared magnitude), and by the shared
// root/divide unit, which resolves one bit per cycle.
`include "assert_macros.svh"

module quaternion_orientation_unit_core
    import qou_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  qou_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output qou_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_MAC   = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_STEP  = 4'd4;
    localparam logic [3:0] ST_ROOT  = 4'd5;
    localparam logic [3:0] ST_DIVGO = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [1:0] PH_HAM  = 2'd0;
    localparam logic [1:0] PH_MAGN = 2'd1;
    localparam logic [1:0] PH_MAT  = 2'd2;
    localparam logic [1:0] PH_MAGU = 2'd3;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_MUL  = 2'd1;
    localparam logic [1:0] MODE_NORM = 2'd2;

    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] COMP_Z   = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ROM_AW-1:0] addr_reg, addr_next;
    logic [ROM_AW-1:0] end_reg, end_next;
    logic [1:0]        comp_reg, comp_next;
    logic [1:0]        row_reg, row_next;
    logic [1:0]        res_row_reg;
    logic [1:0]        res_col_reg;

    qou_in_t              in_reg;
    logic signed [DW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [DW-1:0] tmp_reg [4];
    logic signed [DW-1:0] col_a_reg [3];
    logic signed [DW-1:0] col_b_reg [3];
    logic signed [DW-1:0] col_c_reg [3];
    logic [RAD_W-1:0]     s_reg;
    logic [ROOT_W-1:0]    m_reg;
    logic                 unit_reg;
    logic [TOL_W-1:0]     tol_reg;

    logic                    burst_go;
    logic [ROM_AW-1:0]       burst_base;
    logic [ROM_AW-1:0]       burst_last;
    logic                    load_in;
    logic                    commit_ham;
    logic                    orient_wr;
    logic                    m_wr;
    logic                    unit_wr;
    logic                    mac_issue;
    logic                    rd_start;
    logic                    rd_op;
    qou_term_t               term;
    logic signed [DW-1:0]    op_a;
    logic signed [DW-1:0]    op_b;
    logic                    mac_valid;
    logic signed [ACC_W-1:0] mac_res;
    logic signed [DW-1:0]    mac_scaled;
    qou_rd_res_t             rd_res;
    logic signed [DW-1:0]    div_num;
    logic [ROOT_W-1:0]       mag_diff;
    logic [1:0]              tmp_idx;

    function automatic logic signed [DW-1:0] pick(input logic [2:0] sel,
                                                  input logic signed [DW-1:0] w,
                                                  input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] y,
                                                  input logic signed [DW-1:0] z,
                                                  input qou_in_t i);
        logic signed [DW-1:0] v;
        case (sel)
            SEL_QW:  v = w;
            SEL_QX:  v = x;
            SEL_QY:  v = y;
            SEL_QZ:  v = z;
            SEL_IW:  v = i.in_w;
            SEL_IX:  v = i.in_x;
            SEL_IY:  v = i.in_y;
            default: v = i.in_z;
        endcase
        return v;
    endfunction

    assign term       = term_rom(addr_reg);
    assign op_a       = pick(term.sel_a, qw_reg, qx_reg, qy_reg, qz_reg, in_reg);
    assign op_b       = pick(term.sel_b, qw_reg, qx_reg, qy_reg, qz_reg, in_reg);
    assign div_num    = pick({1'b0, comp_reg}, qw_reg, qx_reg, qy_reg, qz_reg, in_reg);
    assign mac_scaled = scale_sat(mac_res);
    assign tmp_idx    = res_row_reg[0] ? 2'd3 : res_col_reg;
    assign mag_diff   = (rd_res.value >= MAG_ONE) ? rd_res.value - MAG_ONE
                                                  : MAG_ONE - rd_res.value;

    qou_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (mac_issue),
        .op_a      (op_a),
        .op_b      (op_b),
        .ctl       (term.ctl),
        .res_valid (mac_valid),
        .res       (mac_res)
    );

    qou_rootdiv u_rootdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rd_start),
        .op      (rd_op),
        .rad     (s_reg),
        .numer   (div_num),
        .divisor (m_reg),
        .res     (rd_res)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        end_next   = end_reg;
        comp_next  = comp_reg;
        row_next   = row_reg;
        burst_go   = 1'b0;
        burst_base = MAT_BASE;
        burst_last = MAT_LAST;
        load_in    = 1'b0;
        commit_ham = 1'b0;
        orient_wr  = 1'b0;
        m_wr       = 1'b0;
        unit_wr    = 1'b0;
        mac_issue  = 1'b0;
        rd_start   = 1'b0;
        rd_op      = RD_SQRT;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                burst_go   = 1'b1;
                phase_next = PH_MAT;
                case (in_reg.mode)
                    MODE_LOAD: begin
                        load_in = 1'b1;
                    end
                    MODE_MUL: begin
                        burst_base = HAM_BASE;
                        burst_last = HAM_LAST;
                        phase_next = PH_HAM;
                    end
                    MODE_NORM: begin
                        burst_base = MAG_BASE;
                        burst_last = MAG_LAST;
                        phase_next = PH_MAGN;
                    end
                    default: begin
                        phase_next = PH_MAT;
                    end
                endcase
            end
            ST_MAC: begin
                mac_issue = 1'b1;
                if (addr_reg == end_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                case (phase_reg)
                    PH_HAM: begin
                        commit_ham = 1'b1;
                        burst_go   = 1'b1;
                        phase_next = PH_MAT;
                    end
                    PH_MAGN: begin
                        // zero magnitude: leave the quaternion as it is
                        if (s_reg == '0) begin
                            burst_go   = 1'b1;
                            phase_next = PH_MAT;
                        end else begin
                            rd_start   = 1'b1;
                            state_next = ST_ROOT;
                        end
                    end
                    PH_MAT: begin
                        burst_go   = 1'b1;
                        burst_base = MAG_BASE;
                        burst_last = MAG_LAST;
                        phase_next = PH_MAGU;
                    end
                    default: begin
                        rd_start   = 1'b1;
                        state_next = ST_ROOT;
                    end
                endcase
            end
            ST_ROOT: begin
                if (rd_res.done) begin
                    if (phase_reg == PH_MAGN) begin
                        m_wr       = 1'b1;
                        comp_next  = '0;
                        state_next = ST_DIVGO;
                    end else begin
                        unit_wr    = 1'b1;
                        row_next   = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIVGO: begin
                rd_start   = 1'b1;
                rd_op      = RD_DIV;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rd_op = RD_DIV;
                if (rd_res.done) begin
                    orient_wr = 1'b1;
                    if (comp_reg == COMP_Z) begin
                        burst_go   = 1'b1;
                        phase_next = PH_MAT;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = ST_DIVGO;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (row_reg == ROW_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (burst_go) begin
            state_next = ST_MAC;
            addr_next  = burst_base;
            end_next   = burst_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_MAT;
            addr_reg    <= '0;
            end_reg     <= '0;
            comp_reg    <= '0;
            row_reg     <= '0;
            res_row_reg <= '0;
            res_col_reg <= '0;
            qw_reg      <= DW'(1) << FRAC_BITS;
            qx_reg      <= '0;
            qy_reg      <= '0;
            qz_reg      <= '0;
            unit_reg    <= 1'b0;
            tol_reg     <= TOL_RESET;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            end_reg   <= end_next;
            comp_reg  <= comp_next;
            row_reg   <= row_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (burst_go) begin
                res_row_reg <= '0;
                res_col_reg <= '0;
            end else if (mac_valid) begin
                if (res_col_reg == 2'd2) begin
                    res_col_reg <= '0;
                    res_row_reg <= res_row_reg + 1'b1;
                end else begin
                    res_col_reg <= res_col_reg + 1'b1;
                end
            end
            if (load_in) begin
                qw_reg <= in_reg.in_w;
                qx_reg <= in_reg.in_x;
                qy_reg <= in_reg.in_y;
                qz_reg <= in_reg.in_z;
            end else if (commit_ham) begin
                qw_reg <= tmp_reg[0];
                qx_reg <= tmp_reg[1];
                qy_reg <= tmp_reg[2];
                qz_reg <= tmp_reg[3];
            end else if (orient_wr) begin
                case (comp_reg)
                    2'd0:    qw_reg <= rd_res.value[DW-1:0];
                    2'd1:    qx_reg <= rd_res.value[DW-1:0];
                    2'd2:    qy_reg <= rd_res.value[DW-1:0];
                    default: qz_reg <= rd_res.value[DW-1:0];
                endcase
            end
            if (unit_wr) begin
                unit_reg <= (mag_diff < ROOT_W'(tol_reg));
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (m_wr) begin
            m_reg <= rd_res.value;
        end
        if (mac_valid) begin
            case (phase_reg)
                PH_HAM: begin
                    tmp_reg[tmp_idx] <= mac_scaled;
                end
                PH_MAT: begin
                    case (res_col_reg)
                        2'd0:    col_a_reg[res_row_reg] <= mac_scaled;
                        2'd1:    col_b_reg[res_row_reg] <= mac_scaled;
                        default: col_c_reg[res_row_reg] <= mac_scaled;
                    endcase
                end
                default: begin
                    s_reg <= mac_res[RAD_W-1:0];
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        m_data.row_index = row_reg;
        m_data.elem_a    = col_a_reg[row_reg];
        m_data.elem_b    = col_b_reg[row_reg];
        m_data.elem_c    = col_c_reg[row_reg];
        m_data.quat_w    = qw_reg;
        m_data.quat_x    = qx_reg;
        m_data.quat_y    = qy_reg;
        m_data.quat_z    = qz_reg;
        m_data.is_unit   = unit_reg;
        m_data.last_row  = (row_reg == ROW_LAST);
    end

    `QOU_ASSERT_RST(a_no_overlap, aclk, aresetn, !(s_ready && m_valid),
                    "input taken while results pending")
    `QOU_ASSERT_RST(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready,
                    "ready held after accept")
    `QOU_ASSERT_RST(a_idle_after_last, aclk, aresetn,
                    (m_valid && m_ready && m_data.last_row) |=> s_ready,
                    "not idle after last beat")
    `QOU_ASSERT_RST(a_rd_done_state, aclk, aresetn,
                    rd_res.done |-> (state_reg == ST_ROOT || state_reg == ST_DIV),
                    "root/divide finished out of sequence")

endmodule
